// File: rtl/core/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared constants and types for the serial CAN frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

   localparam logic [7:0] SOF_BYTE = 8'h55;
   localparam logic [7:0] HDR_BYTE = 8'hAA;
   localparam logic [7:0] EOF_BYTE = 8'h88;
   localparam logic [4:0] LAST_POS = 5'd27;
   localparam int         BODY_BYTES = 26;
   localparam int         BODY_BITS  = BODY_BYTES * 8;

   typedef enum logic [4:0] {
      PH_START = 5'b00001,
      PH_HEAD  = 5'b00010,
      PH_DATA  = 5'b00100,
      PH_SUM   = 5'b01000,
      PH_END   = 5'b10000
   } phase_type;

   // frame bytes 2..27, byte 2 first
   typedef struct packed {
      logic [7:0]  command;
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [7:0]  tail;
   } frame_type;

   typedef struct packed {
      logic      done;
      frame_type frame;
   } parse_out_type;

endpackage

// File: rtl/core/scfp_in_reg.sv
// ----------------------------------------------------------------------------
// scfp_in_reg
// Input word register; holds a received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module scfp_in_reg import scfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

// File: rtl/core/scfp_parser.sv
// ----------------------------------------------------------------------------
// scfp_parser
// Frame state machine, running checksum and frame body shift register.
// ----------------------------------------------------------------------------
module scfp_parser import scfp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    in_byte,
   output parse_out_type parse_out
);

   phase_type              phase_ff, phase_in;
   logic [4:0]             pos_ff, pos_in;
   logic [7:0]             sum_ff, sum_in;
   logic [BODY_BITS-1:0]   body_ff;
   logic                   shift;
   logic                   done;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      shift    = 1'b0;
      done     = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_HEAD: begin
               if (in_byte == HDR_BYTE) begin
                  sum_in   = sum_ff + in_byte;
                  pos_in   = 5'd2;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_START;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
            PH_DATA: begin
               shift  = 1'b1;
               sum_in = sum_ff + in_byte;
               pos_in = pos_ff + 5'd1;
               if (pos_ff == LAST_POS) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               if (in_byte == sum_ff) begin
                  phase_in = PH_END;
               end else begin
                  phase_in = PH_START;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
            PH_END: begin
               done     = (in_byte == EOF_BYTE);
               phase_in = PH_START;
               pos_in   = '0;
               sum_in   = '0;
            end
            default: begin
               if (in_byte == SOF_BYTE) begin
                  sum_in   = in_byte;
                  pos_in   = 5'd1;
                  phase_in = PH_HEAD;
               end else begin
                  phase_in = PH_START;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pos_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         body_ff <= {body_ff[BODY_BITS-9:0], in_byte};
      end
   end

   assign parse_out.done  = done;
   assign parse_out.frame = frame_type'(body_ff);

endmodule

// File: rtl/core/scfp_out_reg.sv
// ----------------------------------------------------------------------------
// scfp_out_reg
// CAN field decode and result word register.
// ----------------------------------------------------------------------------
module scfp_out_reg import scfp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  parse_out_type parse_out,
   output logic          slot_free,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_command,
   output logic [63:0]   rsp_payload_word0,
   output logic [63:0]   rsp_payload_word1,
   output logic [63:0]   rsp_payload_word2,
   output logic [7:0]    rsp_payload_tail,
   output logic          rsp_can_remote,
   output logic          rsp_can_extended,
   output logic [28:0]   rsp_can_identifier,
   output logic [3:0]    rsp_can_length_code
);

   logic        valid_ff, valid_in;
   frame_type   frame_ff;
   logic [31:0] reg_word;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = parse_out.done || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (parse_out.done) begin
         frame_ff <= parse_out.frame;
      end
   end

   assign reg_word = frame_ff.word0[63:32];

   assign rsp_valid           = valid_ff;
   assign rsp_command         = frame_ff.command;
   assign rsp_payload_word0   = frame_ff.word0;
   assign rsp_payload_word1   = frame_ff.word1;
   assign rsp_payload_word2   = frame_ff.word2;
   assign rsp_payload_tail    = frame_ff.tail;
   assign rsp_can_remote      = reg_word[1];
   assign rsp_can_extended    = reg_word[2];
   assign rsp_can_identifier  = reg_word[2] ? reg_word[31:3] : {18'd0, reg_word[31:21]};
   assign rsp_can_length_code = frame_ff.word0[3:0];

endmodule

// File: rtl/core/serial_can_frame_parser_core.sv
// ----------------------------------------------------------------------------
// serial_can_frame_parser_core
// Byte-serial parser for 30-byte 0x55 0xAA frames with sum8 check and 0x88
// trailer; emits command, payload words and decoded CAN fields.
// ----------------------------------------------------------------------------
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   req_rx_byte (8)
//   rsp      out        rsp_valid/stall   command, payload words, CAN fields
//
// One byte accepted per cycle while req_stall is low; the result register loads
// as the parser takes the trailer byte from the input register, behind that byte.
// Synchronous reset returns the parser to waiting for a start byte.
// A stalled result holds the result register; a byte then waits in the input
// register and req_stall rises only while both are full.
// ----------------------------------------------------------------------------
module serial_can_frame_parser_core import scfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_command,
   output logic [63:0] rsp_payload_word0,
   output logic [63:0] rsp_payload_word1,
   output logic [63:0] rsp_payload_word2,
   output logic [7:0]  rsp_payload_tail,
   output logic        rsp_can_remote,
   output logic        rsp_can_extended,
   output logic [28:0] rsp_can_identifier,
   output logic [3:0]  rsp_can_length_code
);

   logic          in_valid;
   logic [7:0]    in_byte;
   logic          slot_free;
   logic          step;
   parse_out_type parse_out;

   assign step = in_valid && slot_free;

   scfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (slot_free),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   scfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte),
      .parse_out (parse_out)
   );

   scfp_out_reg u_out_reg (
      .clock               (clock),
      .reset               (reset),
      .parse_out           (parse_out),
      .slot_free           (slot_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_command         (rsp_command),
      .rsp_payload_word0   (rsp_payload_word0),
      .rsp_payload_word1   (rsp_payload_word1),
      .rsp_payload_word2   (rsp_payload_word2),
      .rsp_payload_tail    (rsp_payload_tail),
      .rsp_can_remote      (rsp_can_remote),
      .rsp_can_extended    (rsp_can_extended),
      .rsp_can_identifier  (rsp_can_identifier),
      .rsp_can_length_code (rsp_can_length_code)
   );

endmodule
